// ===== rtl/hgrp_pkg.sv =====
// Shared types, constants and character tables for the HTTP GET request parser.
package hgrp_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned HdrCntW  = 8;
  localparam int unsigned MatchW   = 3;
  localparam int unsigned VerTextW = 24;
  localparam int unsigned VerCntW  = 2;

  // Default parameter values and the reset value of the URI limit register.
  localparam int unsigned HeaderCountMaxDef = 255;
  localparam int unsigned UriLimitMaxDef    = 65535;
  localparam logic [CfgW-1:0] MaxUriLengthRst = 16'd2048;

  // Character codes.
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;

  // Match lengths and accepted version strings.
  localparam logic [MatchW-1:0]   MethodLen = 3'd3;
  localparam logic [MatchW-1:0]   ProtoLen  = 3'd5;
  localparam logic [VerCntW-1:0]  VerLen    = 2'd3;
  localparam logic [VerTextW-1:0] Ver10     = 24'h312E30;
  localparam logic [VerTextW-1:0] Ver11     = 24'h312E31;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URI     = 3'd1,
    PH_PROTO   = 3'd2,
    PH_VERSION = 3'd3,
    PH_HEADERS = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERR400  = 3'd6,
    PH_ERR500  = 3'd7
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY   = 2'd0,
    ST_DONE   = 2'd1,
    ST_BAD    = 2'd2,
    ST_TOOLNG = 2'd3
  } status_e;

  // Parser state carried from one word to the next.
  typedef struct packed {
    phase_e                phase;
    logic [MatchW-1:0]     match_idx;
    logic [CfgW-1:0]       uri_cnt;
    logic [VerTextW-1:0]   ver_text;
    logic [VerCntW-1:0]    ver_cnt;
    logic                  mid_line;
    logic                  colon_seen;
    logic [HdrCntW-1:0]    hdr_cnt;
  } state_t;

  // One result word.
  typedef struct packed {
    status_e               status;
    logic [ByteW-1:0]      uri_byte;
    logic                  uri_valid;
    logic                  version_minor;
    logic [HdrCntW-1:0]    header_lines;
  } result_t;

  localparam state_t StateRst = '{
    phase:      PH_METHOD,
    match_idx:  '0,
    uri_cnt:    '0,
    ver_text:   '0,
    ver_cnt:    '0,
    mid_line:   1'b0,
    colon_seen: 1'b0,
    hdr_cnt:    '0
  };

  // Expected character of "GET" at a given match position.
  function automatic logic [ByteW-1:0] method_char(input logic [MatchW-1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h47;
      3'd1:    ch = 8'h45;
      3'd2:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected character of "HTTP/" at a given match position.
  function automatic logic [ByteW-1:0] proto_char(input logic [MatchW-1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [ByteW-1:0] ch);
    return (ch == ChSpace) || (ch == ChTab);
  endfunction

endpackage

// ===== rtl/hgrp_step.sv =====
// Next-state and result logic for one received byte of the request parser.
module hgrp_step #(
  parameter int unsigned HEADER_COUNT_MAX = hgrp_pkg::HeaderCountMaxDef,
  parameter int unsigned URI_LIMIT_MAX    = hgrp_pkg::UriLimitMaxDef
) (
  input  hgrp_pkg::state_t                 cur_i,
  input  logic [hgrp_pkg::ByteW-1:0]       data_byte_i,
  input  logic                             new_request_i,
  input  logic [hgrp_pkg::CfgW-1:0]        max_uri_length_i,
  output hgrp_pkg::state_t                 nxt_o,
  output hgrp_pkg::result_t                res_o
);
  import hgrp_pkg::*;

  // Limits clamped to what the counters can hold.
  localparam logic [CfgW-1:0] UriCap =
    CfgW'((URI_LIMIT_MAX < 65535) ? URI_LIMIT_MAX : 65535);
  localparam logic [HdrCntW-1:0] HdrCap =
    HdrCntW'((HEADER_COUNT_MAX < 255) ? HEADER_COUNT_MAX : 255);

  logic [CfgW-1:0] uri_lim;
  state_t          base;
  state_t          nxt;
  logic [ByteW-1:0] uri_byte;
  logic            uri_valid;
  logic            go;

  assign uri_lim = (max_uri_length_i < UriCap) ? max_uri_length_i : UriCap;

  // Walk the request grammar for one byte.
  always_comb begin
    base      = new_request_i ? StateRst : cur_i;
    nxt       = base;
    uri_byte  = '0;
    uri_valid = 1'b0;
    go        = 1'b1;
    if (data_byte_i != ChCr) begin
      case (base.phase)
        PH_METHOD: begin
          if (base.match_idx < MethodLen && data_byte_i == method_char(base.match_idx)) begin
            if (base.match_idx == MethodLen - 3'd1) begin
              nxt.phase     = PH_URI;
              nxt.match_idx = '0;
            end else begin
              nxt.match_idx = base.match_idx + 3'd1;
            end
          end else begin
            nxt.phase = PH_ERR400;
          end
        end
        PH_URI: begin
          if (is_blank(data_byte_i)) begin
            if (base.uri_cnt != '0) begin
              nxt.phase = PH_PROTO;
            end
          end else if (data_byte_i == ChLf) begin
            nxt.phase = PH_ERR400;
          end else if (base.uri_cnt >= uri_lim) begin
            nxt.phase = PH_ERR500;
          end else begin
            uri_byte    = data_byte_i;
            uri_valid   = 1'b1;
            nxt.uri_cnt = base.uri_cnt + 16'd1;
          end
        end
        PH_PROTO: begin
          if (!(base.match_idx == '0 && is_blank(data_byte_i))) begin
            if (base.match_idx < ProtoLen && data_byte_i == proto_char(base.match_idx)) begin
              nxt.match_idx = base.match_idx + 3'd1;
              if (base.match_idx == ProtoLen - 3'd1) begin
                nxt.phase = PH_VERSION;
              end
            end else begin
              nxt.phase = PH_ERR400;
            end
          end
        end
        PH_VERSION: begin
          if (data_byte_i == ChLf) begin
            if (base.ver_cnt == VerLen && (base.ver_text == Ver10 || base.ver_text == Ver11)) begin
              nxt.phase      = PH_HEADERS;
              nxt.mid_line   = 1'b0;
              nxt.colon_seen = 1'b0;
            end else begin
              nxt.phase = PH_ERR400;
            end
          end else if (base.ver_cnt >= VerLen) begin
            nxt.phase = PH_ERR400;
          end else begin
            nxt.ver_text = {base.ver_text[VerTextW-ByteW-1:0], data_byte_i};
            nxt.ver_cnt  = base.ver_cnt + 2'd1;
          end
        end
        PH_HEADERS: begin
          // Line start: a blank line ends the request, a blank continues a header.
          if (!base.mid_line) begin
            if (data_byte_i == ChLf) begin
              nxt.phase = PH_DONE;
              go        = 1'b0;
            end else if (is_blank(data_byte_i)) begin
              nxt.mid_line = 1'b1;
              go           = 1'b0;
            end else begin
              nxt.colon_seen = 1'b0;
            end
          end
          // One colon per header, continuation lines included.
          if (go && data_byte_i == ChColon) begin
            if (nxt.colon_seen) begin
              nxt.phase = PH_ERR400;
              go        = 1'b0;
            end else begin
              nxt.colon_seen = 1'b1;
            end
          end
          if (go) begin
            if (data_byte_i == ChLf) begin
              nxt.mid_line = 1'b0;
              if (base.hdr_cnt < HdrCap) begin
                nxt.hdr_cnt = base.hdr_cnt + 8'd1;
              end
            end else begin
              nxt.mid_line = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word built from the updated state.
  always_comb begin
    res_o.uri_byte      = uri_byte;
    res_o.uri_valid     = uri_valid;
    res_o.version_minor = (nxt.ver_text == Ver11);
    res_o.header_lines  = nxt.hdr_cnt;
    case (nxt.phase)
      PH_DONE:   res_o.status = ST_DONE;
      PH_ERR400: res_o.status = ST_BAD;
      PH_ERR500: res_o.status = ST_TOOLNG;
      default:   res_o.status = ST_BUSY;
    endcase
  end

  assign nxt_o = nxt;

endmodule

// ===== rtl/http_get_request_parser.sv =====
// Top level of the HTTP GET request parser: state, limit register and result register.
// The parser takes one request byte per word and returns one result word for each,
// in the cycle after the byte is taken. The parse state is updated when the byte is
// taken and the result goes to an output register, so in_ready_o stays high while
// that register is empty or is being drained in the same cycle. The sustained rate
// is one byte per cycle while the receiver takes every result word. Raise new_request_i
// with the first byte of a connection to restart the parser. max_uri_length is written
// through cfg_we_i and cfg_wdata_i and resets to 2048.
module http_get_request_parser #(
  parameter int unsigned HEADER_COUNT_MAX = hgrp_pkg::HeaderCountMaxDef,
  parameter int unsigned URI_LIMIT_MAX    = hgrp_pkg::UriLimitMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration.
  input  logic                           cfg_we_i,
  input  logic [hgrp_pkg::CfgW-1:0]      cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hgrp_pkg::ByteW-1:0]     data_byte_i,
  input  logic                           new_request_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hgrp_pkg::StatusW-1:0]   status_o,
  output logic [hgrp_pkg::ByteW-1:0]     uri_byte_o,
  output logic                           uri_valid_o,
  output logic                           version_minor_o,
  output logic [hgrp_pkg::HdrCntW-1:0]   header_lines_o
);
  import hgrp_pkg::*;

  logic [CfgW-1:0] max_uri_q;
  state_t          state_q;
  state_t          state_d;
  result_t         res_d;
  result_t         res_q;
  logic            out_valid_q;
  logic            in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  hgrp_step #(
    .HEADER_COUNT_MAX(HEADER_COUNT_MAX),
    .URI_LIMIT_MAX   (URI_LIMIT_MAX)
  ) u_step (
    .cur_i           (state_q),
    .data_byte_i     (data_byte_i),
    .new_request_i   (new_request_i),
    .max_uri_length_i(max_uri_q),
    .nxt_o           (state_d),
    .res_o           (res_d)
  );

  // URI length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_uri_q <= MaxUriLengthRst;
    end else if (cfg_we_i) begin
      max_uri_q <= cfg_wdata_i;
    end
  end

  // Parse state advances on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign uri_byte_o      = res_q.uri_byte;
  assign uri_valid_o     = res_q.uri_valid;
  assign version_minor_o = res_q.version_minor;
  assign header_lines_o  = res_q.header_lines;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the HTTP GET request parser, driven with byte streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hgrp_pkg::*;

  typedef logic [ByteW-1:0] byte_q_t[$];

  localparam int unsigned HdrCap     = (HeaderCountMaxDef < 255) ? HeaderCountMaxDef : 255;
  localparam int unsigned CycleLimit = 400000;
  localparam int          PhaseBytes = 25;

  // Tracks the parse of the byte stream and holds the result words still owed by the block.
  class parser_scoreboard;
    logic [CfgW-1:0]     uri_max;
    phase_e              phase;
    logic [MatchW-1:0]   midx;
    logic [16:0]         uri_cnt;
    logic [VerTextW-1:0] ver_text;
    logic [VerCntW-1:0]  ver_cnt;
    logic                mid_line;
    logic                colon_seen;
    logic [HdrCntW-1:0]  hdr_cnt;
    result_t             pending_results[$];
    int                  errors;
    string               method_txt = "GET";
    string               proto_txt = "HTTP/";

    function new();
      uri_max = MaxUriLengthRst;
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_METHOD;
      midx = '0;
      uri_cnt = '0;
      ver_text = '0;
      ver_cnt = '0;
      mid_line = 1'b0;
      colon_seen = 1'b0;
      hdr_cnt = '0;
    endfunction

    function bit spacing(logic [ByteW-1:0] c);
      return (c == ChSpace) || (c == ChTab);
    endfunction

    // Advance the parse by one accepted word and queue the result it must produce.
    function void note_byte(logic [ByteW-1:0] c, logic nr);
      result_t     r;
      logic [16:0] lim;
      r = '0;
      lim = (uri_max < UriLimitMaxDef) ? 17'(uri_max) : 17'(UriLimitMaxDef);
      if (nr) restart();
      if (c != ChCr) begin
        case (phase)
          PH_METHOD: begin
            if (midx < MethodLen && c == method_txt[midx]) begin
              midx = midx + 3'd1;
              if (midx == MethodLen) begin
                phase = PH_URI;
                midx = '0;
              end
            end else phase = PH_ERR400;
          end
          PH_URI: begin
            if (spacing(c)) begin
              if (uri_cnt != 0) phase = PH_PROTO;
            end else if (c == ChLf) phase = PH_ERR400;
            else if (uri_cnt >= lim) phase = PH_ERR500;
            else begin
              r.uri_byte = c;
              r.uri_valid = 1'b1;
              uri_cnt = uri_cnt + 17'd1;
            end
          end
          PH_PROTO: begin
            // Blanks are skipped only before the first protocol character.
            if (!(midx == 0 && spacing(c))) begin
              if (midx < ProtoLen && c == proto_txt[midx]) begin
                midx = midx + 3'd1;
                if (midx == ProtoLen) phase = PH_VERSION;
              end else phase = PH_ERR400;
            end
          end
          PH_VERSION: begin
            if (c == ChLf) begin
              if (ver_cnt == VerLen && (ver_text == Ver10 || ver_text == Ver11)) begin
                phase = PH_HEADERS;
                mid_line = 1'b0;
                colon_seen = 1'b0;
              end else phase = PH_ERR400;
            end else if (ver_cnt >= VerLen) phase = PH_ERR400;
            else begin
              ver_text = {ver_text[VerTextW-9:0], c};
              ver_cnt = ver_cnt + 2'd1;
            end
          end
          PH_HEADERS: begin
            // A line that starts with a blank continues the previous header.
            if (!mid_line && c == ChLf) phase = PH_DONE;
            else if (!mid_line && spacing(c)) mid_line = 1'b1;
            else begin
              if (!mid_line) colon_seen = 1'b0;
              if (c == ChColon && colon_seen) phase = PH_ERR400;
              else begin
                if (c == ChColon) colon_seen = 1'b1;
                if (c == ChLf) begin
                  mid_line = 1'b0;
                  if (hdr_cnt < HdrCap) hdr_cnt = hdr_cnt + 8'd1;
                end else mid_line = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      case (phase)
        PH_DONE:   r.status = ST_DONE;
        PH_ERR400: r.status = ST_BAD;
        PH_ERR500: r.status = ST_TOOLNG;
        default:   r.status = ST_BUSY;
      endcase
      r.version_minor = (ver_text == Ver11);
      r.header_lines = hdr_cnt;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      end
    endfunction

    // Compare one accepted result word with the oldest one owed.
    function void check_word(logic [StatusW-1:0] st, logic [ByteW-1:0] ub, logic uv,
                             logic vm, logic [HdrCntW-1:0] hl);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, status %0h", $time, st);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, st);
      compare_field("uri_byte", want.uri_byte, ub);
      compare_field("uri_valid", want.uri_valid, uv);
      compare_field("version_minor", want.version_minor, vm);
      compare_field("header_lines", want.header_lines, hl);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ByteW-1:0]     data_byte_i = '0;
  logic                 new_request_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [ByteW-1:0]     uri_byte_o;
  logic                 uri_valid_o;
  logic                 version_minor_o;
  logic [HdrCntW-1:0]   header_lines_o;

  parser_scoreboard sb = new();
  int               burst_left = 0;
  int               gap_mode = 0;
  int               rx_mode = 0;
  logic [2:0]       rx_tick = '0;
  int unsigned      cycle_count = 0;

  http_get_request_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .new_request_i   (new_request_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .uri_byte_o      (uri_byte_o),
    .uri_valid_o     (uri_valid_o),
    .version_minor_o (version_minor_o),
    .header_lines_o  (header_lines_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver backpressure; the pattern is switched by the stimulus as the run goes on.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 3'd1;
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 9) < 3);
      default: out_ready_i <= (rx_tick < 3'd5);
    endcase
  end

  // Handshake monitor: the input word is noted before any result of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i, new_request_i);
      if (out_valid_o && out_ready_i)
        sb.check_word(status_o, uri_byte_o, uri_valid_o, version_minor_o, header_lines_o);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Present one byte, opening a new burst after a random gap when the last one ran out.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic nr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, (gap_mode == 1) ? 3 : 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        data_byte_i <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    new_request_i <= nr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_seq(ref byte_q_t seq, input bit open_new, input int restart_at);
    foreach (seq[i]) send_byte(seq[i], (i == 0 && open_new) || i == restart_at);
  endtask

  // Stop sending and let every owed result drain before touching the register.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_uri_limit(input logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.uri_max = v;
  endtask

  function automatic void add_text(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_blanks(ref byte_q_t q, input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) q.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
  endfunction

  function automatic void add_eol(ref byte_q_t q);
    if ($urandom_range(0, 1)) q.push_back(ChCr);
    q.push_back(ChLf);
  endfunction

  // Header text; a stray colon is let through now and then.
  function automatic logic [ByteW-1:0] header_char();
    logic [ByteW-1:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == ChColon && $urandom_range(0, 3) != 0) c = "v";
    return c;
  endfunction

  // A GET request with random URI, version and header content; the version is sometimes malformed.
  function automatic void build_request(ref byte_q_t q);
    logic [ByteW-1:0] c;
    string            ver_pool;
    ver_pool = "01.2";
    add_text(q, "GET");
    add_blanks(q, 0, 2);
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10)) begin
      c = 8'($urandom_range(0, 255));
      if (c == ChSpace || c == ChTab || c == ChLf) c = "u";
      q.push_back(c);
    end
    add_blanks(q, 1, 2);
    add_text(q, "HTTP/");
    if ($urandom_range(0, 7) != 0) add_text(q, $urandom_range(0, 1) ? "1.1" : "1.0");
    else repeat ($urandom_range(0, 4)) q.push_back(ver_pool[$urandom_range(0, 3)]);
    add_eol(q);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(97, 122)));
      q.push_back(ChColon);
      add_blanks(q, 0, 1);
      repeat ($urandom_range(0, 5)) q.push_back(header_char());
      add_eol(q);
      if ($urandom_range(0, 4) == 0) begin
        add_blanks(q, 1, 2);
        repeat ($urandom_range(1, 4)) q.push_back(header_char());
        add_eol(q);
      end
    end
    add_eol(q);
  endfunction

  // Break a request: overwrite, cut, insert, or restart the parser partway through.
  function automatic void damage(ref byte_q_t q, ref int restart_at);
    int pos;
    pos = $urandom_range(0, q.size() - 1);
    case ($urandom_range(0, 3))
      0:       q[pos] = 8'($urandom_range(0, 255));
      1:       while (q.size() > pos + 1) void'(q.pop_back());
      2:       q.insert(pos, 8'($urandom_range(0, 255)));
      default: restart_at = pos;
    endcase
  endfunction

  task automatic random_phase(input int budget);
    byte_q_t seq;
    int      restart_at;
    int      sent;
    bit      open_new;
    sent = 0;
    while (sent < budget) begin
      seq = {};
      restart_at = -1;
      open_new = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        rx_mode = $urandom_range(0, 3);
        gap_mode = $urandom_range(0, 2);
      end
      if ($urandom_range(0, 6) == 0) begin
        // Raw noise, with new_request set at random.
        repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
        open_new = $urandom_range(0, 1);
        restart_at = $urandom_range(0, 6);
      end else begin
        build_request(seq);
        if ($urandom_range(0, 3) == 0) damage(seq, restart_at);
        if ($urandom_range(0, 19) == 0) open_new = 1'b0;
      end
      send_seq(seq, open_new, restart_at);
      sent += seq.size();
    end
  endtask

  initial begin : main_seq
    byte_q_t          seq;
    logic [CfgW-1:0]  plan[6];
    plan[0] = 16'd1;
    plan[1] = 16'd65535;
    plan[2] = 16'd3;
    plan[3] = 16'd16;
    plan[4] = 16'($urandom_range(2, 12));
    plan[5] = 16'($urandom_range(17, 65535));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: newline before the URI, then a byte that must be ignored.
    add_text(seq, "GET\n");
    seq.push_back(8'hFF);
    send_seq(seq, 1'b1, -1);
    // Carriage returns and a tab everywhere, high URI byte, HTTP/1.1 with no headers.
    seq = {};
    add_text(seq, "\015GE\015T\t/");
    seq.push_back(8'h80);
    add_text(seq, " HTTP/1.1\015\n\015\n");
    send_seq(seq, 1'b1, -1);
    // Version one character too long, then an unknown version.
    seq = {};
    add_text(seq, "GET /a HTTP/1.11");
    send_seq(seq, 1'b1, -1);
    seq = {};
    add_text(seq, "GET x HTTP/2.0\n");
    send_seq(seq, 1'b1, -1);
    // Second colon on a continuation line of the same header.
    seq = {};
    add_text(seq, "GET x HTTP/1.0\nk:v\n\t:x\n");
    send_seq(seq, 1'b1, -1);

    random_phase(PhaseBytes);
    foreach (plan[i]) begin
      wait_idle();
      write_uri_limit(plan[i]);
      if (plan[i] == 16'd65535) begin
        // Enough header lines to saturate the count.
        seq = {};
        add_text(seq, "GET / HTTP/1.1\n");
        repeat (HdrCap + 2) add_text(seq, "h\n");
        add_text(seq, "\n");
        send_seq(seq, 1'b1, -1);
      end
      random_phase(PhaseBytes);
    end
    wait_idle();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
